@@ sv/mp3_pkg.sv @@
package mp3_pkg;

    // Geometry defaults for the top-level parameters
    localparam int MP3_MAX_WIDTH    = 256;
    localparam int MP3_MAX_CHANNELS = 64;
    localparam int MP3_MAX_HEIGHT   = 1024;

    // Window size, fixed by the pooling scheme
    localparam int WIN = 3;

    // Sample width (signed Q8.8)
    localparam int SAMPLE_W = 16;

    // Configuration register widths
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_HEIGHT_W = 11;
    localparam int CFG_WIDTH_W  = 9;
    localparam int CFG_CHAN_W   = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_MODE     = 2'd3;

    // Pool modes
    localparam logic MODE_3X3 = 1'b0;
    localparam logic MODE_3X1 = 1'b1;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;

    // Per-item control flags handed from front to back
    typedef struct packed {
        logic first;   // first sample of its window: overwrite the store entry
        logic emit;    // last sample of its window: deliver the maximum
        logic done;    // last pooled value of the image
    } mp3_ctl_t;

    localparam int CTL_W = $bits(mp3_ctl_t);

endpackage

@@ sv/mp3_front.sv @@
module mp3_front
    import mp3_pkg::*;
#(
    parameter int MAX_WIDTH    = MP3_MAX_WIDTH,
    parameter int MAX_CHANNELS = MP3_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = MP3_MAX_HEIGHT,
    parameter int AW           = 14
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    input  logic                       q_full,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       push,
    output logic [AW-1:0]              push_idx,
    output logic signed [SAMPLE_W-1:0] push_sample,
    output mp3_ctl_t                   push_ctl
);

    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int HXW = HW + 2;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int WXW = WW + 2;
    localparam int CHW = $clog2(MAX_CHANNELS + 1);
    localparam int KW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Configuration registers
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_CHAN_W-1:0]   chan_reg;
    logic                    mode_reg;

    // Stream position
    logic [KW-1:0] k_reg;
    logic [WW-1:0] c_reg;
    logic [1:0]    m3_reg;
    logic [WW-1:0] w3_reg;
    logic [HW-1:0] r_reg;
    logic [1:0]    l_reg;

    logic [HW-1:0]  h_cl;
    logic [WW-1:0]  w_cl;
    logic [CHW-1:0] ch_cl;
    logic           accept;
    logic [HW-1:0]  rb;
    logic [WW-1:0]  cb;
    logic           row_ok;
    logic           row_last;
    logic           col_ok;
    logic           first_col;
    logic           last_col;
    logic           win_last;
    logic [WW-1:0]  win_sel;
    logic           k_last;
    logic [CHW-1:0] k_inc;
    logic [WXW-1:0] c_inc;
    logic [HXW-1:0] r_inc;

    // Saturate the registers to their usable ranges
    always_comb
    begin
        if (height_reg < CFG_HEIGHT_W'(WIN))
            h_cl = HW'(WIN);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_cl = HW'(MAX_HEIGHT);
        else
            h_cl = HW'(height_reg);

        if (width_reg == '0)
            w_cl = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_cl = WW'(MAX_WIDTH);
        else
            w_cl = WW'(width_reg);

        if (chan_reg == '0)
            ch_cl = CHW'(1);
        else if (32'(chan_reg) > MAX_CHANNELS)
            ch_cl = CHW'(MAX_CHANNELS);
        else
            ch_cl = CHW'(chan_reg);
    end

    assign accept = in_valid && !q_full;

    // Classify the item: window, first and last sample, image end
    always_comb
    begin
        rb       = r_reg - HW'(l_reg);
        cb       = c_reg - WW'(m3_reg);
        row_ok   = (HXW'(rb) + HXW'(WIN)) <= HXW'(h_cl);
        row_last = (l_reg == 2'(WIN - 1)) && ((HXW'(rb) + HXW'(2 * WIN)) > HXW'(h_cl));
        k_inc    = CHW'(k_reg) + CHW'(1);
        k_last   = k_inc >= ch_cl;
        c_inc    = WXW'(c_reg) + WXW'(1);
        r_inc    = HXW'(r_reg) + HXW'(1);

        if (mode_reg == MODE_3X1)
        begin
            col_ok    = 1'b1;
            first_col = 1'b1;
            last_col  = 1'b1;
            win_sel   = c_reg;
            win_last  = (WXW'(c_reg) + WXW'(1)) >= WXW'(w_cl);
        end
        else if (w_cl >= WW'(WIN))
        begin
            col_ok    = (WXW'(cb) + WXW'(WIN)) <= WXW'(w_cl);
            first_col = (m3_reg == 2'd0);
            last_col  = (m3_reg == 2'(WIN - 1));
            win_sel   = w3_reg;
            win_last  = (WXW'(cb) + WXW'(2 * WIN)) > WXW'(w_cl);
        end
        else
        begin
            col_ok    = 1'b1;
            first_col = (c_reg == '0);
            last_col  = (WXW'(c_reg) + WXW'(1)) >= WXW'(w_cl);
            win_sel   = '0;
            win_last  = 1'b1;
        end

        push_idx       = AW'(win_sel) * AW'(MAX_CHANNELS) + AW'(k_reg);
        push_sample    = sample;
        push_ctl.first = (l_reg == 2'd0) && first_col;
        push_ctl.emit  = (l_reg == 2'(WIN - 1)) && last_col;
        push_ctl.done  = push_ctl.emit && row_last && win_last && k_last;
        push           = accept && row_ok && col_ok;
    end

    // Hold configuration and advance the stream position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= CFG_HEIGHT_W'(WIN);
            width_reg  <= CFG_WIDTH_W'(WIN);
            chan_reg   <= CFG_CHAN_W'(1);
            mode_reg   <= MODE_3X3;
            k_reg      <= '0;
            c_reg      <= '0;
            m3_reg     <= '0;
            w3_reg     <= '0;
            r_reg      <= '0;
            l_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[CFG_CHAN_W-1:0];
                CFG_POOL_MODE:     mode_reg   <= cfg_data[0];
                default:           mode_reg   <= mode_reg;
            endcase
            // restart at the top of a new image
            k_reg  <= '0;
            c_reg  <= '0;
            m3_reg <= '0;
            w3_reg <= '0;
            r_reg  <= '0;
            l_reg  <= '0;
        end
        else if (accept)
        begin
            if (!k_last)
                k_reg <= k_reg + KW'(1);
            else
            begin
                k_reg <= '0;
                if (c_inc >= WXW'(w_cl))
                begin
                    c_reg  <= '0;
                    m3_reg <= '0;
                    w3_reg <= '0;
                    if (r_inc >= HXW'(h_cl))
                    begin
                        r_reg <= '0;
                        l_reg <= '0;
                    end
                    else
                    begin
                        r_reg <= r_inc[HW-1:0];
                        l_reg <= (l_reg == 2'(WIN - 1)) ? 2'd0 : l_reg + 2'd1;
                    end
                end
                else
                begin
                    c_reg <= c_inc[WW-1:0];
                    if (m3_reg == 2'(WIN - 1))
                    begin
                        m3_reg <= 2'd0;
                        w3_reg <= w3_reg + WW'(1);
                    end
                    else
                        m3_reg <= m3_reg + 2'd1;
                end
            end
        end
    end

endmodule

@@ sv/mp3_queue.sv @@
module mp3_queue
    import mp3_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = QDEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    input  logic          pop,
    output logic [DW-1:0] rdata,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] head_reg;
    logic [PW-1:0] tail_reg;
    logic [NW-1:0] count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[head_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= (32'(tail_reg) == DEPTH - 1) ? '0 : tail_reg + PW'(1);
            if (pop)
                head_reg <= (32'(head_reg) == DEPTH - 1) ? '0 : head_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + NW'(1);
            else if (pop && !push)
                count_reg <= count_reg - NW'(1);
        end
    end

    // Store the item at the tail
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[tail_reg] <= wdata;
    end

endmodule

@@ sv/mp3_back.sv @@
module mp3_back
    import mp3_pkg::*;
#(
    parameter int MAX_WIDTH    = MP3_MAX_WIDTH,
    parameter int MAX_CHANNELS = MP3_MAX_CHANNELS,
    parameter int AW           = 14
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  logic [AW-1:0]              q_idx,
    input  logic signed [SAMPLE_W-1:0] q_sample,
    input  mp3_ctl_t                   q_ctl,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] pooled,
    output logic                       image_done
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;

    // Line store of partial maxima
    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    // Update stage
    logic                       b_valid_reg;
    logic [AW-1:0]              b_idx_reg;
    logic signed [SAMPLE_W-1:0] b_sample_reg;
    mp3_ctl_t                   b_ctl_reg;
    logic signed [SAMPLE_W-1:0] rd_reg;
    logic                       byp_reg;
    logic signed [SAMPLE_W-1:0] byp_val_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] pooled_reg;
    logic                       done_reg;

    logic                       out_free;
    logic                       b_fire;
    logic signed [SAMPLE_W-1:0] old_val;
    logic signed [SAMPLE_W-1:0] new_val;

    // Merge the sample into the window maximum; derive stage firing and pop
    always_comb
    begin
        old_val  = byp_reg ? byp_val_reg : rd_reg;
        if (b_ctl_reg.first || (b_sample_reg > old_val))
            new_val = b_sample_reg;
        else
            new_val = old_val;
        out_free = !out_valid_reg || !out_stall;
        b_fire   = b_valid_reg && (!b_ctl_reg.emit || out_free);
        pop      = !q_empty && (!b_valid_reg || b_fire);
    end

    // Control: stage and output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                b_valid_reg <= 1'b1;
            else if (b_fire)
                b_valid_reg <= 1'b0;

            if (b_fire && b_ctl_reg.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: read the store on pop, write back when the stage retires, capture emitted results
    always_ff @(posedge clk)
    begin
        if (b_fire)
            mem[b_idx_reg] <= new_val;

        if (pop)
        begin
            b_idx_reg    <= q_idx;
            b_sample_reg <= q_sample;
            b_ctl_reg    <= q_ctl;
            rd_reg       <= mem[q_idx];
            // forward the value being written to the same entry
            byp_reg      <= b_fire && (b_idx_reg == q_idx);
            byp_val_reg  <= new_val;
        end

        if (b_fire && b_ctl_reg.emit)
        begin
            pooled_reg <= new_val;
            done_reg   <= b_ctl_reg.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pooled     = pooled_reg;
    assign image_done = done_reg;

endmodule

@@ sv/max_pool_3x3_stride3_stream.sv @@
// Streaming max pooling over signed Q8.8 feature maps.
// Input channel: sample with in_valid / in_stall, one item per cycle, in row,
// column, channel order (channel innermost), image after image without gaps.
// Output channel: pooled and image_done with out_valid / out_stall; image_done
// marks the last pooled value of an image.
// Configuration: cfg_write, cfg_index, cfg_data; index 0 height, 1 width,
// 2 channel count, 3 mode (0 = 3x3 stride 3, 1 = 3x1 over rows). Any write
// restarts the stream at the top of a new image; write only while idle.
// Throughput: one item per cycle while out_stall is low. Each item does one
// read-modify-write of the line store, one read and one write per cycle;
// a same-entry hit on back-to-back items is forwarded from the update stage.
// The item that closes a window passes through the queue, the update stage and
// the output register before its window maximum appears on out_valid.
// Reset: geometry returns to 3x3 pixels, one channel, mode 0, position zero;
// the line store is not cleared, since each window's first sample writes it.
// Receiver stall: the output register holds its item, the update stage and
// then the four-entry queue fill, and in_stall rises once the queue is full.
module max_pool_3x3_stride3_stream
    import mp3_pkg::*;
#(
    parameter int MAX_WIDTH    = MP3_MAX_WIDTH,
    parameter int MAX_CHANNELS = MP3_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = MP3_MAX_HEIGHT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] pooled,
    output logic                       image_done
);

    localparam int AW = (MAX_WIDTH * MAX_CHANNELS > 1) ?
                        $clog2(MAX_WIDTH * MAX_CHANNELS) : 1;
    localparam int DW = AW + SAMPLE_W + CTL_W;

    logic                       push;
    logic [AW-1:0]              push_idx;
    logic signed [SAMPLE_W-1:0] push_sample;
    mp3_ctl_t                   push_ctl;
    logic                       q_full;
    logic                       q_empty;
    logic                       pop;
    logic [DW-1:0]              q_rdata;
    logic [AW-1:0]              q_idx;
    logic signed [SAMPLE_W-1:0] q_sample;
    mp3_ctl_t                   q_ctl;

    assign in_stall = q_full;

    // Accept and classify items
    mp3_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .AW           (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .q_full      (q_full),
        .sample      (sample),
        .push        (push),
        .push_idx    (push_idx),
        .push_sample (push_sample),
        .push_ctl    (push_ctl)
    );

    // Decouple front from back
    mp3_queue #(
        .DW    (DW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({push_idx, push_sample, push_ctl}),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_idx    = q_rdata[DW-1 -: AW];
    assign q_sample = q_rdata[CTL_W +: SAMPLE_W];
    assign q_ctl    = q_rdata[CTL_W-1:0];

    // Update the line store and deliver results
    mp3_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_idx      (q_idx),
        .q_sample   (q_sample),
        .q_ctl      (q_ctl),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pooled     (pooled),
        .image_done (image_done)
    );

endmodule
